// ===== hdl/ssfp_pkg.sv =====
package ssfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 4;
   localparam int unsigned WORD_W = 16;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [POS_W-1:0]  frame_pos_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam byte_type      HEADER_BYTE   = 8'hFF;
   localparam frame_pos_type POS_IDLE      = 4'd0;
   localparam frame_pos_type FIRST_PAYLOAD = 4'd2;
   localparam frame_pos_type POS_HIGH      = 4'd5;
   localparam frame_pos_type POS_LOW       = 4'd6;
   localparam frame_pos_type POS_CHECK     = 4'd7;
   localparam frame_pos_type FRAME_LEN     = 4'd8;

endpackage

// ===== hdl/ssfp_req_if.sv =====
interface ssfp_req_if;
   import ssfp_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     overrun;

   modport source (output valid, output data_byte, output overrun, input ready);
   modport sink   (input valid, input data_byte, input overrun, output ready);

endinterface

// ===== hdl/ssfp_rsp_if.sv =====
interface ssfp_rsp_if;
   import ssfp_pkg::*;

   logic     valid;
   logic     ready;
   word_type position;
   logic     checksum_ok;

   modport source (output valid, output position, output checksum_ok, input ready);
   modport sink   (input valid, input position, input checksum_ok, output ready);

endinterface

// ===== hdl/servo_status_frame_parser.sv =====
// Requests enter the input register; frame results leave the result register.
// Throughput: one request per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset (synchronous, active high): parser state cleared, no frame open,
// no header pending, both registers emptied.
module servo_status_frame_parser (
   input logic        clock,
   input logic        reset,
   ssfp_req_if.sink   req_chan,
   ssfp_rsp_if.source rsp_chan
);
   import ssfp_pkg::*;

   // input register
   logic          in_valid_ff, in_valid_in;
   byte_type      in_data_ff, in_data_in;
   logic          in_ovr_ff, in_ovr_in;

   // parser state
   logic          hdr_pending_ff, hdr_pending_in;
   frame_pos_type frame_pos_ff, frame_pos_in;
   byte_type      sum_ff, sum_in;
   byte_type      pos_high_ff, pos_high_in;
   byte_type      pos_low_ff, pos_low_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   word_type      out_pos_ff, out_pos_in;
   logic          out_ok_ff, out_ok_in;

   logic          advance;
   logic          emit;
   logic          is_header;
   logic          frame_open;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign is_header  = (in_data_ff == HEADER_BYTE);
   assign frame_open = (frame_pos_ff >= FIRST_PAYLOAD) && (frame_pos_ff < FRAME_LEN);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_ovr_in   = in_ovr_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_data_in  = req_chan.data_byte;
         in_ovr_in   = req_chan.overrun;
      end
   end

   always_comb begin
      hdr_pending_in = hdr_pending_ff;
      frame_pos_in   = frame_pos_ff;
      sum_in         = sum_ff;
      pos_high_in    = pos_high_ff;
      pos_low_in     = pos_low_ff;
      emit           = 1'b0;
      if (advance && in_valid_ff && !in_ovr_ff) begin
         if (is_header && !hdr_pending_ff) begin
            hdr_pending_in = 1'b1;
         end else if (is_header) begin
            hdr_pending_in = 1'b0;
            frame_pos_in   = FIRST_PAYLOAD;
            sum_in         = '0;
         end else if (!frame_open) begin
            frame_pos_in = POS_IDLE;
         end else begin
            if (frame_pos_ff <= POS_LOW) begin
               sum_in = sum_ff + in_data_ff;
            end
            if (frame_pos_ff == POS_HIGH) begin
               pos_high_in = in_data_ff;
            end
            if (frame_pos_ff == POS_LOW) begin
               pos_low_in = in_data_ff;
            end
            if (frame_pos_ff == POS_CHECK) begin
               emit         = 1'b1;
               frame_pos_in = POS_IDLE;
            end else begin
               frame_pos_in = frame_pos_ff + 4'd1;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pos_in   = out_pos_ff;
      out_ok_in    = out_ok_ff;
      if (advance) begin
         out_valid_in = emit;
         out_pos_in   = {pos_high_ff, pos_low_ff};
         out_ok_in    = (~sum_ff == in_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         hdr_pending_ff <= 1'b0;
         frame_pos_ff   <= POS_IDLE;
         sum_ff         <= '0;
         pos_high_ff    <= '0;
         pos_low_ff     <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         hdr_pending_ff <= hdr_pending_in;
         frame_pos_ff   <= frame_pos_in;
         sum_ff         <= sum_in;
         pos_high_ff    <= pos_high_in;
         pos_low_ff     <= pos_low_in;
      end
      in_data_ff <= in_data_in;
      in_ovr_ff  <= in_ovr_in;
      out_pos_ff <= out_pos_in;
      out_ok_ff  <= out_ok_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.position    = out_pos_ff;
   assign rsp_chan.checksum_ok = out_ok_ff;

   a_pos_legal: assert property (@(posedge clock) disable iff (reset)
      (frame_pos_ff != POS_IDLE) |-> (frame_pos_ff >= FIRST_PAYLOAD && frame_pos_ff <= POS_CHECK))
      else $error("frame position out of range");

   a_emit_closes: assert property (@(posedge clock) disable iff (reset)
      emit |=> (frame_pos_ff == POS_IDLE && out_valid_ff))
      else $error("frame not closed after result");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff) && $stable(in_ovr_ff)))
      else $error("stalled request lost");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(frame_pos_ff) && $stable(sum_ff) && $stable(hdr_pending_ff)))
      else $error("parser state moved during stall");

endmodule

// ===== dv/ssfp_status_checker.sv =====
`timescale 1ns / 100ps

module ssfp_status_checker (
   input  logic clock,
   input  logic reset,
   ssfp_req_if  req_chan,
   ssfp_rsp_if  rsp_chan,
   output int   error_count,
   output int   outstanding
);
   import ssfp_pkg::*;

   typedef struct packed {
      word_type position;
      logic     checksum_ok;
   } status_type;

   status_type    pending_status [$];

   // parser state as seen by the predictor
   logic          hdr_pending;
   frame_pos_type frame_pos;
   byte_type      body_sum;
   byte_type      pos_hi;
   byte_type      pos_lo;
   int            mismatches;

   function automatic void parse_status_byte(input byte_type data);
      logic       in_frame;
      byte_type   want_sum;
      status_type status;
      in_frame = (frame_pos >= FIRST_PAYLOAD) && (frame_pos < FRAME_LEN);
      if (data == HEADER_BYTE) begin
         // header never lands in the payload, even mid-frame
         if (!hdr_pending) begin
            hdr_pending = 1'b1;
         end else begin
            hdr_pending = 1'b0;
            frame_pos   = FIRST_PAYLOAD;
            body_sum    = '0;
         end
      end else if (!in_frame) begin
         frame_pos = POS_IDLE;
      end else begin
         if (frame_pos < POS_CHECK) body_sum = body_sum + data;
         if (frame_pos == POS_HIGH) pos_hi = data;
         else if (frame_pos == POS_LOW) pos_lo = data;
         if (frame_pos == POS_CHECK) begin
            want_sum           = ~body_sum;
            status.position    = {pos_hi, pos_lo};
            status.checksum_ok = (want_sum == data);
            pending_status.push_back(status);
            frame_pos = POS_IDLE;
         end else begin
            frame_pos = frame_pos + 4'd1;
         end
      end
   endfunction

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         hdr_pending = 1'b0;
         frame_pos   = POS_IDLE;
         body_sum    = '0;
         pos_hi      = '0;
         pos_lo      = '0;
         mismatches  = 0;
         pending_status.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.position    = rsp_chan.position;
            got.checksum_ok = rsp_chan.checksum_ok;
            if (pending_status.size() == 0) begin
               $error("unexpected status: position %h checksum_ok %b",
                      got.position, got.checksum_ok);
               mismatches++;
            end else begin
               want = pending_status.pop_front();
               if (got.position !== want.position) begin
                  $error("position: expected %h actual %h", want.position, got.position);
                  mismatches++;
               end
               if (got.checksum_ok !== want.checksum_ok) begin
                  $error("checksum_ok: expected %b actual %b",
                         want.checksum_ok, got.checksum_ok);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready && !req_chan.overrun)
            parse_status_byte(req_chan.data_byte);
      end
      error_count <= mismatches;
      outstanding <= pending_status.size();
   end

endmodule

// ===== dv/tb_servo_status_frame_parser.sv =====
`timescale 1ns / 100ps

module tb_servo_status_frame_parser;
   import ssfp_pkg::*;

   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_START  = 1200;
   localparam int HOLD_CYCLES = 300;

   // {overrun, data_byte}
   localparam logic [8:0] DIRECTED [22] = '{
      9'h000, 9'h1FF, 9'h0FF, 9'h0FF, 9'h001, 9'h002, 9'h003, 9'h0FE,
      9'h0FE, 9'h0FD, 9'h0FF, 9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h180,
      9'h000, 9'h000, 9'h000, 9'h000, 9'h055, 9'h0FF
   };

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   sent_count;
   int   burst_left;
   int   error_count;
   int   outstanding;

   ssfp_req_if req_if ();
   ssfp_rsp_if rsp_if ();

   servo_status_frame_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   ssfp_status_checker i_status_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic byte_type rand_payload();
      if ($urandom_range(0, 7) == 0)
         return ($urandom_range(0, 1) != 0) ? 8'hFE : 8'h00;
      return 8'($urandom_range(0, 254));
   endfunction

   // offers one request, maybe after a gap when the current burst is used up
   task automatic push_byte(input byte_type data, input logic ovr);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.overrun   <= ovr;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   task automatic send_frame(input logic good_sum, input logic stray_header);
      byte_type total;
      byte_type data;
      int       stray_at;
      total    = '0;
      stray_at = stray_header ? $urandom_range(0, 5) : -1;
      push_byte(HEADER_BYTE, 1'b0);
      push_byte(HEADER_BYTE, 1'b0);
      for (int k = 0; k < 6; k++) begin
         if ($urandom_range(0, 15) == 0) push_byte(8'($urandom_range(0, 255)), 1'b1);
         if (k == stray_at) push_byte(HEADER_BYTE, 1'b0);
         if (k < 5) begin
            data  = rand_payload();
            total = total + data;
         end else begin
            data = ~total;
            if (!good_sum || data == HEADER_BYTE) data = rand_payload();
         end
         push_byte(data, 1'b0);
      end
   endtask

   // receiver: random stall modes, plus one long hold-off to back up the block
   initial begin : rx_pattern
      int   rx_cycles;
      int   mode;
      int   phase_len;
      logic hold_done;
      rx_cycles = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         if (!hold_done && rx_cycles >= HOLD_START) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode      = $urandom_range(0, 3);
         phase_len = $urandom_range(20, 200);
         repeat (phase_len) begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
            rx_cycles++;
         end
      end
   end

   initial begin : stimulus
      int kind;
      sent_count  = 0;
      burst_left  = 0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.overrun   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) push_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

      while (sent_count < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            send_frame($urandom_range(0, 3) != 0, 1'b0);
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 6))
               push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else if (kind == 8) begin
            // truncated frame, cut off by whatever comes next
            push_byte(HEADER_BYTE, 1'b0);
            push_byte(HEADER_BYTE, 1'b0);
            repeat ($urandom_range(0, 4)) push_byte(rand_payload(), 1'b0);
         end else begin
            send_frame(1'b1, 1'b1);
         end
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ssfp_pkg.sv
hdl/ssfp_req_if.sv
hdl/ssfp_rsp_if.sv
hdl/servo_status_frame_parser.sv
dv/ssfp_status_checker.sv
dv/tb_servo_status_frame_parser.sv
